FILE: hdl/afns_pkg.sv
package afns_pkg;

   localparam int CW   = 11;
   localparam int PIXW = 32;
   localparam int REGW = 12;
   localparam int IDXW = 2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [IDXW-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [IDXW-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [IDXW-1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [IDXW-1:0] REG_DST_HEIGHT = 2'd3;

   // one classified beat between front and back
   typedef struct packed {
      logic            is_read;
      logic            border;
      logic [CW-1:0]   u;
      logic [CW-1:0]   v;
      logic [PIXW-1:0] pixel;
   } item_type;

endpackage

FILE: hdl/afns_geom.sv
module afns_geom import afns_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = 1280,
   parameter int MAX_SRC_HEIGHT = 720,
   parameter int MAX_DST_WIDTH  = 2048,
   parameter int MAX_DST_HEIGHT = 1200,
   parameter int SDW = 11,
   parameter int DDW = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [IDXW-1:0] csr_index,
   input  logic [REGW-1:0] csr_wdata,
   output logic            ready,
   output logic [SDW-1:0]  fw,
   output logic [SDW-1:0]  fh,
   output logic [DDW-1:0]  dw,
   output logic [DDW-1:0]  dh,
   output logic [DDW-1:0]  sw,
   output logic [DDW-1:0]  sh,
   output logic [DDW-1:0]  ox0,
   output logic [DDW-1:0]  oy0
);

   localparam int PW   = SDW + DDW;
   localparam int CNTW = $clog2(PW);

   typedef enum logic [2:0] {G_MUL, G_SETUP, G_DIV, G_FIN, G_IDLE} gstate_type;

   gstate_type       state_ff;
   logic [10:0]      src_width_ff;
   logic [9:0]       src_height_ff;
   logic [11:0]      dst_width_ff;
   logic [10:0]      dst_height_ff;
   logic [SDW-1:0]   fw_ff, fh_ff, fw_c, fh_c;
   logic [DDW-1:0]   dw_ff, dh_ff, dw_c, dh_c;
   logic [DDW-1:0]   sw_ff, sh_ff, ox0_ff, oy0_ff, sw_v, sh_v;
   logic [PW-1:0]    pa_ff, pb_ff, num_ff, num_in;
   logic [SDW-1:0]   den_ff;
   logic [SDW:0]     rem_ff, rem_in, rem_sh;
   logic [CNTW-1:0]  cnt_ff;
   logic             letter_ff;

   always_comb begin
      fw_c = (src_width_ff == '0) ? SDW'(1) :
             (32'(src_width_ff) > 32'(MAX_SRC_WIDTH)) ? SDW'(MAX_SRC_WIDTH) : SDW'(src_width_ff);
      fh_c = (src_height_ff == '0) ? SDW'(1) :
             (32'(src_height_ff) > 32'(MAX_SRC_HEIGHT)) ? SDW'(MAX_SRC_HEIGHT) : SDW'(src_height_ff);
      dw_c = (dst_width_ff == '0) ? DDW'(1) :
             (32'(dst_width_ff) > 32'(MAX_DST_WIDTH)) ? DDW'(MAX_DST_WIDTH) : DDW'(dst_width_ff);
      dh_c = (dst_height_ff == '0) ? DDW'(1) :
             (32'(dst_height_ff) > 32'(MAX_DST_HEIGHT)) ? DDW'(MAX_DST_HEIGHT) : DDW'(dst_height_ff);
      // restoring divide, one quotient bit per cycle
      rem_sh = {rem_ff[SDW-1:0], num_ff[PW-1]};
      if (rem_sh >= {1'b0, den_ff}) begin
         rem_in = rem_sh - {1'b0, den_ff};
         num_in = {num_ff[PW-2:0], 1'b1};
      end else begin
         rem_in = rem_sh;
         num_in = {num_ff[PW-2:0], 1'b0};
      end
      sw_v = letter_ff ? dw_ff : DDW'(num_ff);
      sh_v = letter_ff ? DDW'(num_ff) : dh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= G_MUL;
         src_width_ff  <= 11'd1280;
         src_height_ff <= 10'd720;
         dst_width_ff  <= 12'd1280;
         dst_height_ff <= 11'd720;
      end else if (csr_we) begin
         state_ff <= G_MUL;
         case (csr_index)
            REG_SRC_WIDTH:  src_width_ff  <= csr_wdata[10:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_wdata[9:0];
            REG_DST_WIDTH:  dst_width_ff  <= csr_wdata[11:0];
            REG_DST_HEIGHT: dst_height_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end else begin
         case (state_ff)
            G_MUL: begin
               fw_ff    <= fw_c;
               fh_ff    <= fh_c;
               dw_ff    <= dw_c;
               dh_ff    <= dh_c;
               pa_ff    <= PW'(fw_c) * PW'(dh_c);
               pb_ff    <= PW'(fh_c) * PW'(dw_c);
               state_ff <= G_SETUP;
            end
            G_SETUP: begin
               letter_ff <= pa_ff > pb_ff;
               num_ff    <= (pa_ff > pb_ff) ? pb_ff : pa_ff;
               den_ff    <= (pa_ff > pb_ff) ? fw_ff : fh_ff;
               rem_ff    <= '0;
               cnt_ff    <= '0;
               state_ff  <= G_DIV;
            end
            G_DIV: begin
               rem_ff <= rem_in;
               num_ff <= num_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNTW'(PW - 1)) state_ff <= G_FIN;
            end
            G_FIN: begin
               sw_ff    <= sw_v;
               sh_ff    <= sh_v;
               ox0_ff   <= (dw_ff - sw_v) >> 1;
               oy0_ff   <= (dh_ff - sh_v) >> 1;
               state_ff <= G_IDLE;
            end
            default: state_ff <= G_IDLE;
         endcase
      end
   end

   assign ready = (state_ff == G_IDLE);
   assign fw  = fw_ff;
   assign fh  = fh_ff;
   assign dw  = dw_ff;
   assign dh  = dh_ff;
   assign sw  = sw_ff;
   assign sh  = sh_ff;
   assign ox0 = ox0_ff;
   assign oy0 = oy0_ff;

endmodule

FILE: hdl/afns_front.sv
module afns_front import afns_pkg::*; #(
   parameter int SDW = 11,
   parameter int DDW = 12
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           geom_ready,
   input  logic [SDW-1:0] fw,
   input  logic [SDW-1:0] fh,
   input  logic [DDW-1:0] dw,
   input  logic [DDW-1:0] dh,
   input  logic [DDW-1:0] sw,
   input  logic [DDW-1:0] sh,
   input  logic [DDW-1:0] ox0,
   input  logic [DDW-1:0] oy0,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic           in_kind,
   input  logic [CW-1:0]  in_x,
   input  logic [CW-1:0]  in_y,
   input  logic [PIXW-1:0] in_pixel,
   output logic           q_valid,
   output item_type       q_item,
   input  logic           q_pop
);

   localparam int EW0 = (SDW > DDW) ? SDW : DDW;
   localparam int EW  = ((EW0 > CW) ? EW0 : CW) + 1;
   localparam int QD  = 4;
   localparam int QPW = $clog2(QD);

   item_type        fifo_ff [QD];
   logic [QPW-1:0]  wp_ff, rp_ff;
   logic [QPW:0]    cnt_ff;
   logic [EW-1:0]   xe, ye, oxe, oye;
   logic            outside, inframe, push, accept;
   item_type        itm;

   always_comb begin
      xe  = EW'(in_x);
      ye  = EW'(in_y);
      oxe = EW'(ox0);
      oye = EW'(oy0);
      outside = (xe >= EW'(dw)) || (ye >= EW'(dh)) || (xe < oxe) || (xe >= oxe + EW'(sw))
                || (ye < oye) || (ye >= oye + EW'(sh));
      inframe = (xe < EW'(fw)) && (ye < EW'(fh));
      itm.is_read = (in_kind == KIND_READ);
      itm.border  = outside;
      itm.u       = itm.is_read ? CW'(xe - oxe) : in_x;
      itm.v       = itm.is_read ? CW'(ye - oye) : in_y;
      itm.pixel   = in_pixel;
   end

   assign in_ready = geom_ready && (cnt_ff != (QPW+1)'(QD));
   assign accept   = in_valid && in_ready;
   // writes outside the source frame are dropped here
   assign push     = accept && (itm.is_read || inframe);
   assign q_valid  = (cnt_ff != '0);
   assign q_item   = fifo_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wp_ff] <= itm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push)  wp_ff <= wp_ff + 1'b1;
         if (q_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPW+1)'(push) - (QPW+1)'(q_pop);
      end
   end

endmodule

FILE: hdl/afns_back.sv
module afns_back import afns_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = 1280,
   parameter int MAX_SRC_HEIGHT = 720,
   parameter int SDW = 11,
   parameter int DDW = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [SDW-1:0]  fw,
   input  logic [SDW-1:0]  fh,
   input  logic [DDW-1:0]  sw,
   input  logic [DDW-1:0]  sh,
   input  logic            q_valid,
   input  item_type        q_item,
   output logic            q_pop,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [PIXW-1:0] out_pixel,
   output logic            out_border
);

   localparam int QW    = SDW;
   localparam int RW    = CW + SDW + DDW;
   localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   logic            adv;
   logic            vld_ff [QW+1];
   item_type        itm_ff [QW+1];
   logic [RW-1:0]   rx_ff  [QW+1];
   logic [RW-1:0]   ry_ff  [QW+1];
   logic [QW-1:0]   qx_ff  [QW+1];
   logic [QW-1:0]   qy_ff  [QW+1];
   logic            av_ff, mv_ff;
   item_type        aitm_ff;
   logic [QW-1:0]   aqx_ff, aqy_ff;
   logic [AW-1:0]   addr_ff;
   logic [QW-1:0]   sx, sy;
   logic            mrd_ff, mbd_ff;
   logic [PIXW-1:0] mem [DEPTH];
   logic [PIXW-1:0] rd_ff;
   logic            ov_ff, ob_ff;
   logic [PIXW-1:0] op_ff;

   assign adv   = !ov_ff || out_ready;
   assign q_pop = adv && q_valid;

   // multiply stage: numerators of both axes
   always_ff @(posedge clock) begin
      if (adv) begin
         itm_ff[0] <= q_item;
         rx_ff[0]  <= RW'(q_item.u) * RW'(fw);
         ry_ff[0]  <= RW'(q_item.v) * RW'(fh);
         qx_ff[0]  <= '0;
         qy_ff[0]  <= '0;
      end
   end

   // one quotient bit per stage on each axis
   for (genvar g = 0; g < QW; g++) begin : g_div
      localparam int B = QW - 1 - g;
      logic [RW-1:0] dxs, dys;
      logic          cx, cy;
      assign dxs = RW'(sw) << B;
      assign dys = RW'(sh) << B;
      assign cx  = rx_ff[g] >= dxs;
      assign cy  = ry_ff[g] >= dys;
      always_ff @(posedge clock) begin
         if (adv) begin
            itm_ff[g+1] <= itm_ff[g];
            rx_ff[g+1]  <= cx ? rx_ff[g] - dxs : rx_ff[g];
            ry_ff[g+1]  <= cy ? ry_ff[g] - dys : ry_ff[g];
            qx_ff[g+1]  <= {qx_ff[g][QW-2:0], cx};
            qy_ff[g+1]  <= {qy_ff[g][QW-2:0], cy};
         end
      end
      always_ff @(posedge clock) begin
         if (reset)    vld_ff[g+1] <= 1'b0;
         else if (adv) vld_ff[g+1] <= vld_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    vld_ff[0] <= 1'b0;
      else if (adv) vld_ff[0] <= q_pop;
   end

   assign sx = itm_ff[QW].is_read ? qx_ff[QW] : QW'(itm_ff[QW].u);
   assign sy = itm_ff[QW].is_read ? qy_ff[QW] : QW'(itm_ff[QW].v);

   // address stage, then store access, then output register
   always_ff @(posedge clock) begin
      if (adv) begin
         aitm_ff <= itm_ff[QW];
         aqx_ff  <= qx_ff[QW];
         aqy_ff  <= qy_ff[QW];
         addr_ff <= AW'(sy) * AW'(MAX_SRC_WIDTH) + AW'(sx);
         if (av_ff && !aitm_ff.is_read) mem[addr_ff] <= aitm_ff.pixel;
         rd_ff   <= mem[addr_ff];
         mrd_ff  <= aitm_ff.is_read;
         mbd_ff  <= aitm_ff.border;
         ob_ff   <= mbd_ff;
         op_ff   <= mbd_ff ? '0 : rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
         mv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         av_ff <= vld_ff[QW];
         mv_ff <= av_ff;
         ov_ff <= mv_ff && mrd_ff;
      end
   end

   assign out_valid  = ov_ff;
   assign out_pixel  = op_ff;
   assign out_border = ob_ff;

   a_border_black: assert property (@(posedge clock) disable iff (reset)
      ov_ff && ob_ff |-> op_ff == '0) else $error("border beat with nonzero pixel");
   a_sx_range: assert property (@(posedge clock) disable iff (reset)
      av_ff && aitm_ff.is_read && !aitm_ff.border |-> aqx_ff < fw)
      else $error("column quotient out of range");
   a_sy_range: assert property (@(posedge clock) disable iff (reset)
      av_ff && aitm_ff.is_read && !aitm_ff.border |-> aqy_ff < fh)
      else $error("row quotient out of range");

endmodule

FILE: hdl/aspect_fit_nearest_scaler_unit.sv
// Nearest-neighbor scaler with letterbox/pillarbox fit.
// req channel: tuser = kind (0 write source pixel, 1 read display pixel);
//   tdata = coord_x, coord_y, pixel_in. Writes outside the source frame are
//   dropped; writes give no rsp beat.
// rsp channel: one beat per read; tdata = pixel_out, tuser = is_border.
// csr port: write enable, index (0 src_width, 1 src_height, 2 dst_width,
//   3 dst_height) and data; write only while the block is idle.
// Throughput: one beat per cycle, back to back, reads and writes mixed, while
//   the geometry is ready and the queue has room. Reads pass through a
//   bit-per-stage divider (SDW is the source size width, 11 at default).
// After reset and after every csr write the fit geometry is recomputed by a
//   serial divider; req_tready stays low until it is done. The frame store
//   is not cleared.
// While an rsp beat waits with rsp_tready low the back pipeline holds; a
//   4-beat queue keeps taking req beats until it fills, then req_tready drops.
module aspect_fit_nearest_scaler_unit import afns_pkg::*; #(
   parameter int MAX_SRC_WIDTH  = 1280,
   parameter int MAX_SRC_HEIGHT = 720,
   parameter int MAX_DST_WIDTH  = 2048,
   parameter int MAX_DST_HEIGHT = 1200
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [55:0]     req_tdata,  // coord_x[10:0], coord_y[21:11], pixel_in[53:22]
   input  logic            req_tuser,  // kind
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [31:0]     rsp_tdata,  // pixel_out[31:0]
   output logic            rsp_tuser,  // is_border
   input  logic            csr_we,
   input  logic [IDXW-1:0] csr_index,
   input  logic [REGW-1:0] csr_wdata
);

   localparam int SMAX = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
   localparam int DMAX = (MAX_DST_WIDTH > MAX_DST_HEIGHT) ? MAX_DST_WIDTH : MAX_DST_HEIGHT;
   localparam int SDW  = $clog2(SMAX + 1);
   localparam int DDW  = $clog2(DMAX + 1);

   logic           geom_ready, q_valid, q_pop;
   item_type       q_item;
   logic [SDW-1:0] fw, fh;
   logic [DDW-1:0] dw, dh, sw, sh, ox0, oy0;

   afns_geom #(
      .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
      .MAX_DST_WIDTH(MAX_DST_WIDTH), .MAX_DST_HEIGHT(MAX_DST_HEIGHT),
      .SDW(SDW), .DDW(DDW)
   ) u_geom (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .ready(geom_ready), .fw(fw), .fh(fh), .dw(dw), .dh(dh),
      .sw(sw), .sh(sh), .ox0(ox0), .oy0(oy0)
   );

   afns_front #(.SDW(SDW), .DDW(DDW)) u_front (
      .clock(clock), .reset(reset), .geom_ready(geom_ready),
      .fw(fw), .fh(fh), .dw(dw), .dh(dh), .sw(sw), .sh(sh), .ox0(ox0), .oy0(oy0),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_kind(req_tuser),
      .in_x(req_tdata[10:0]), .in_y(req_tdata[21:11]), .in_pixel(req_tdata[53:22]),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   afns_back #(
      .MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
      .SDW(SDW), .DDW(DDW)
   ) u_back (
      .clock(clock), .reset(reset), .fw(fw), .fh(fh), .sw(sw), .sh(sh),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_pixel(rsp_tdata), .out_border(rsp_tuser)
   );

endmodule
